FILE: sv/cfpd_pkg.sv
// ----------------------------------------------------------------------------
// cfpd_pkg
// Shared types and constants of the complex field peak detector.
// ----------------------------------------------------------------------------
package cfpd_pkg;

  // fixed field and register widths
  localparam int MAG_W      = 32;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int ROW_W      = 12;
  localparam int PCOL_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_HEIGHT     = 4096;
  localparam int CFG_WIDTH_RST  = 1024;
  localparam int CFG_HEIGHT_RST = 1024;

  // module parameter defaults
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // result queue
  localparam int PUSH_MAX   = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } cfg_reg_t;

  // where the sample sits in the frame
  typedef struct packed {
    logic up1;       // row above exists
    logic up2;       // two rows above exist
    logic left1;     // column to the left exists
    logic left2;     // two columns to the left exist
    logic right;     // column to the right exists
    logic last_row;
    logic last_col;
  } pos_flags_t;

  // one line memory entry: squared magnitudes of rows r-1 and r-2
  typedef struct packed {
    logic [MAG_W-1:0] mid;
    logic [MAG_W-1:0] up;
  } line_entry_t;

  // squared magnitudes around the current sample
  typedef struct packed {
    logic [MAG_W-1:0] h;         // current sample (r, c)
    logic [MAG_W-1:0] mid_c;     // (r-1, c)
    logic [MAG_W-1:0] up_c;      // (r-2, c)
    logic [MAG_W-1:0] mid_n;     // (r-1, c+1)
    logic [MAG_W-1:0] left_mid;  // (r-1, c-1)
    logic [MAG_W-1:0] prev1_h;   // (r, c-1)
    logic [MAG_W-1:0] prev2_h;   // (r, c-2)
  } nbr_t;

  typedef struct packed {
    logic [PCOL_W-1:0] peak_col;
    logic [ROW_W-1:0]  peak_row;
    logic [MAG_W-1:0]  height_sq;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [1:0]              cnt;
    res_t [PUSH_MAX-1:0]     slot;
  } push_t;

  typedef struct packed {
    logic not_empty;
    logic room;        // space for a full run of results
  } fifo_stat_t;

endpackage

FILE: sv/cfpd_ram.sv
// ----------------------------------------------------------------------------
// cfpd_ram
// Generic RAM, one write port and two registered read ports, write-first.
// ----------------------------------------------------------------------------
module cfpd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_a_r;
  logic [WIDTH-1:0] rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a_r <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem_r[rd_addr_a];
      rd_data_b_r <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem_r[rd_addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

FILE: sv/cfpd_mag.sv
// ----------------------------------------------------------------------------
// cfpd_mag
// Squared magnitude re*re + im*im, saturated to 32 bits.
// ----------------------------------------------------------------------------
module cfpd_mag
  import cfpd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic signed [SAMPLE_BITS-1:0] re,
  input  logic signed [SAMPLE_BITS-1:0] im,
  output logic [MAG_W-1:0]              mag_sq
);

  localparam int SUM_W = 2 * SAMPLE_BITS;

  logic signed [SUM_W-1:0] re_sq;
  logic signed [SUM_W-1:0] im_sq;
  logic [SUM_W-1:0]        sum;
  logic                    sat;

  assign re_sq = re * re;
  assign im_sq = im * im;
  // both squares are non-negative and their sum fits in SUM_W bits
  assign sum   = $unsigned(re_sq) + $unsigned(im_sq);
  assign sat   = (SUM_W > MAG_W) && (sum > SUM_W'({MAG_W{1'b1}}));

  assign mag_sq = sat ? {MAG_W{1'b1}} : MAG_W'(sum);

endmodule

FILE: sv/cfpd_judge.sv
// ----------------------------------------------------------------------------
// cfpd_judge
// Local maximum tests for the up to three samples decided by one input word.
// ----------------------------------------------------------------------------
module cfpd_judge
  import cfpd_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic [$clog2(MAX_WIDTH)-1:0] col,
  input  logic [ROW_W-1:0]             row,
  input  pos_flags_t                   flags,
  input  nbr_t                         nbr,
  input  logic [MAG_W-1:0]             thresh,
  output push_t                        push
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  // upper and left neighbours may tie, lower and right must be smaller
  function automatic logic peak_ok(
    input logic [MAG_W-1:0] h,
    input logic [MAG_W-1:0] thr,
    input logic hu, input logic [MAG_W-1:0] u,
    input logic hl, input logic [MAG_W-1:0] l,
    input logic hd, input logic [MAG_W-1:0] d,
    input logic hr, input logic [MAG_W-1:0] r
  );
    return (h > thr) && !(hu && (h < u)) && !(hl && (h < l)) &&
           !(hd && (h <= d)) && !(hr && (h <= r));
  endfunction

  logic [PUSH_MAX-1:0] hit;
  res_t                cand [PUSH_MAX];
  logic [1:0]          idx;

  always_comb begin
    // sample above the current one, now that its lower neighbour is here
    hit[0] = flags.up1 &&
             peak_ok(nbr.mid_c, thresh, flags.up2, nbr.up_c, flags.left1, nbr.left_mid,
                     1'b1, nbr.h, flags.right, nbr.mid_n);
    // last row: sample to the left, now that its right neighbour is here
    hit[1] = flags.last_row && flags.left1 &&
             peak_ok(nbr.prev1_h, thresh, flags.up1, nbr.left_mid, flags.left2, nbr.prev2_h,
                     1'b0, '0, 1'b1, nbr.h);
    // last sample of the frame
    hit[2] = flags.last_row && flags.last_col &&
             peak_ok(nbr.h, thresh, flags.up1, nbr.mid_c, flags.left1, nbr.prev1_h,
                     1'b0, '0, 1'b0, '0);

    cand[0] = '{peak_col: PCOL_W'(col), peak_row: ROW_W'(row - 1'b1),
                height_sq: nbr.mid_c, last: 1'b0};
    cand[1] = '{peak_col: PCOL_W'(COL_W'(col - 1'b1)), peak_row: row,
                height_sq: nbr.prev1_h, last: 1'b0};
    cand[2] = '{peak_col: PCOL_W'(col), peak_row: row,
                height_sq: nbr.h, last: 1'b0};
  end

  // pack the hits in order and flag the final one
  always_comb begin
    push = '0;
    idx  = '0;
    for (int k = 0; k < PUSH_MAX; k++) begin
      if (hit[k]) begin
        push.slot[idx] = cand[k];
        idx            = idx + 1'b1;
      end
    end
    push.cnt = idx;
    if (idx != '0) begin
      push.slot[idx - 1'b1].last = 1'b1;
    end
  end

endmodule

FILE: sv/cfpd_res_fifo.sv
// ----------------------------------------------------------------------------
// cfpd_res_fifo
// Result queue: takes up to three words at once, gives one per cycle on pop.
// ----------------------------------------------------------------------------
module cfpd_res_fifo
  import cfpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_en,
  input  push_t      push,
  input  logic       pop,
  output res_t       head,
  output fifo_stat_t stat
);

  res_t             q_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [LVL_W-1:0] push_cnt;

  assign push_cnt   = push_en ? LVL_W'(push.cnt) : '0;
  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign level_nxt  = level_r + push_cnt - LVL_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PUSH_MAX; k++) begin
      if (push_en && (k < int'(push.cnt))) begin
        q_r[wr_ptr_r + PTR_W'(k)] <= push.slot[k];
      end
    end
  end

  assign head           = q_r[rd_ptr_r];
  assign stat.not_empty = (level_r != '0);
  assign stat.room      = (level_r <= LVL_W'(FIFO_DEPTH - PUSH_MAX));

endmodule

FILE: sv/complex_field_peak_detector.sv
// ----------------------------------------------------------------------------
// complex_field_peak_detector
// Squared magnitude and 4-neighbour local maximum search over a raster frame.
// ----------------------------------------------------------------------------
// Throughput: one input word per cycle; in_stall rises only while the result
//   queue holds more than one word (a run of peaks in the last row, or
//   results held back by out_stall).
// Pipeline: an accepted word passes the input stage (magnitude, line memory
//   read), then the judging stage, then the result queue; in_stall holds it.
// Reset (synchronous): clears pipeline, result queue, raster position and
//   registers (threshold 0, 1024 x 1024); the line memory is not cleared.
// ----------------------------------------------------------------------------
module complex_field_peak_detector
  import cfpd_pkg::*;
#(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_re_part,
  input  logic signed [SAMPLE_BITS-1:0] in_im_part,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [PCOL_W-1:0]             out_peak_col,
  output logic [ROW_W-1:0]              out_peak_row,
  output logic [MAG_W-1:0]              out_height_sq,
  output logic                          out_last_of_run
);

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int RST_WIDTH  = (MAX_WIDTH < CFG_WIDTH_RST) ? MAX_WIDTH : CFG_WIDTH_RST;
  localparam int RST_HEIGHT = CFG_HEIGHT_RST;

  // configuration
  logic [MAG_W-1:0] thresh_r;
  logic [COL_W-1:0] last_col_r, last_col_nxt;
  logic [ROW_W-1:0] last_row_r, last_row_nxt;
  logic [FW_W-1:0]  cfg_fw;
  logic [FH_W-1:0]  cfg_fh;
  logic             geom_wr;

  // raster position of the next word
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic       pipe_en;
  logic       in_acc;
  pos_flags_t flags_nxt;

  // input stage
  logic                          s1_valid_r;
  logic signed [SAMPLE_BITS-1:0] s1_re_r;
  logic signed [SAMPLE_BITS-1:0] s1_im_r;
  logic [COL_W-1:0]              s1_col_r;
  logic [ROW_W-1:0]              s1_row_r;
  pos_flags_t                    s1_flags_r;
  logic [MAG_W-1:0]              s1_mag;
  line_entry_t                   line_cur;
  line_entry_t                   line_next;
  line_entry_t                   line_wr;
  logic [COL_W-1:0]              rd_addr_b;

  // previous columns of the current row and of the row above
  logic [MAG_W-1:0] prev1_h_r;
  logic [MAG_W-1:0] prev2_h_r;
  logic [MAG_W-1:0] prev1_mid_r;

  // judging stage
  logic             s2_valid_r;
  logic [COL_W-1:0] s2_col_r;
  logic [ROW_W-1:0] s2_row_r;
  pos_flags_t       s2_flags_r;
  nbr_t             s2_nbr_r;

  push_t      push;
  res_t       head;
  fifo_stat_t fifo_stat;
  logic       pop;

  assign pipe_en  = fifo_stat.room;
  assign in_stall = !pipe_en;
  assign in_acc   = in_valid && pipe_en;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  assign cfg_fw  = cfg_wdata[FW_W-1:0];
  assign cfg_fh  = cfg_wdata[FH_W-1:0];
  assign geom_wr = cfg_wr_en &&
                   ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

  always_comb begin
    // saturate geometry to 1..MAX_WIDTH and 1..MAX_HEIGHT, keep it minus one
    if (cfg_fw == '0) begin
      last_col_nxt = '0;
    end else if (int'(cfg_fw) > MAX_WIDTH) begin
      last_col_nxt = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col_nxt = COL_W'(cfg_fw - 1'b1);
    end
    if (cfg_fh == '0) begin
      last_row_nxt = '0;
    end else if (int'(cfg_fh) > MAX_HEIGHT) begin
      last_row_nxt = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      last_row_nxt = ROW_W'(cfg_fh - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r   <= '0;
      last_col_r <= COL_W'(RST_WIDTH - 1);
      last_row_r <= ROW_W'(RST_HEIGHT - 1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_THRESHOLD: thresh_r   <= cfg_wdata;
        REG_WIDTH:     last_col_r <= last_col_nxt;
        REG_HEIGHT:    last_row_r <= last_row_nxt;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // raster position
  // --------------------------------------------------------------------------
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    priority if (geom_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (col_r == last_col_r) begin
        col_nxt = '0;
        row_nxt = (row_r == last_row_r) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_comb begin
    flags_nxt.up1      = (row_r != '0);
    flags_nxt.up2      = (row_r > ROW_W'(1));
    flags_nxt.left1    = (col_r != '0);
    flags_nxt.left2    = (col_r > COL_W'(1));
    flags_nxt.right    = (col_r != last_col_r);
    flags_nxt.last_row = (row_r == last_row_r);
    flags_nxt.last_col = (col_r == last_col_r);
  end

  // --------------------------------------------------------------------------
  // input stage and line memory
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_re_r    <= in_re_part;
      s1_im_r    <= in_im_part;
      s1_col_r   <= col_r;
      s1_row_r   <= row_r;
      s1_flags_r <= flags_nxt;
    end
  end

  // right-hand entry is only used when it lies inside the row
  assign rd_addr_b = flags_nxt.right ? col_r + 1'b1 : '0;

  // column c holds {row r-1, row r-2}; the word moves it down one row
  assign line_wr.mid = s1_mag;
  assign line_wr.up  = line_cur.mid;

  cfpd_ram #(
    .WIDTH ($bits(line_entry_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk       (clk),
    .wr_en     (s1_valid_r && pipe_en),
    .wr_addr   (s1_col_r),
    .wr_data   (line_wr),
    .rd_en     (in_acc),
    .rd_addr_a (col_r),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (line_cur),
    .rd_data_b (line_next)
  );

  cfpd_mag #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mag (
    .re     (s1_re_r),
    .im     (s1_im_r),
    .mag_sq (s1_mag)
  );

  // --------------------------------------------------------------------------
  // judging stage
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && pipe_en) begin
      s2_col_r          <= s1_col_r;
      s2_row_r          <= s1_row_r;
      s2_flags_r        <= s1_flags_r;
      s2_nbr_r.h        <= s1_mag;
      s2_nbr_r.mid_c    <= line_cur.mid;
      s2_nbr_r.up_c     <= line_cur.up;
      s2_nbr_r.mid_n    <= line_next.mid;
      s2_nbr_r.left_mid <= prev1_mid_r;
      s2_nbr_r.prev1_h  <= prev1_h_r;
      s2_nbr_r.prev2_h  <= prev2_h_r;
      prev2_h_r         <= prev1_h_r;
      prev1_h_r         <= s1_mag;
      prev1_mid_r       <= line_cur.mid;
    end
  end

  cfpd_judge #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_judge (
    .col    (s2_col_r),
    .row    (s2_row_r),
    .flags  (s2_flags_r),
    .nbr    (s2_nbr_r),
    .thresh (thresh_r),
    .push   (push)
  );

  // --------------------------------------------------------------------------
  // result queue
  // --------------------------------------------------------------------------
  assign pop = fifo_stat.not_empty && !out_stall;

  cfpd_res_fifo u_res_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_en (s2_valid_r && pipe_en),
    .push    (push),
    .pop     (pop),
    .head    (head),
    .stat    (fifo_stat)
  );

  assign out_valid       = fifo_stat.not_empty;
  assign out_peak_col    = head.peak_col;
  assign out_peak_row    = head.peak_row;
  assign out_height_sq   = head.height_sq;
  assign out_last_of_run = head.last;

endmodule

FILE: sv/cfpd_checker.sv
// ----------------------------------------------------------------------------
// cfpd_checker
// Port-level checks of the peak detector, bound to the top level.
// ----------------------------------------------------------------------------
module cfpd_checker
  import cfpd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [PCOL_W-1:0] out_peak_col,
  input logic [ROW_W-1:0]  out_peak_row,
  input logic [MAG_W-1:0]  out_height_sq,
  input logic              out_last_of_run
);

  // reset leaves no result pending and the input open
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result pending or input stalled after reset");

  // a held result word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_peak_col) && $stable(out_peak_row) &&
      $stable(out_height_sq) && $stable(out_last_of_run))
    else $error("stalled result word changed");

  // the words of one run are queued together, so the run never breaks up
  a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid)
    else $error("run of results broken before its last word");

  // a peak lies strictly above the threshold, which is never negative
  a_height_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_height_sq != '0)
    else $error("peak with zero height reported");

endmodule

bind complex_field_peak_detector cfpd_checker u_cfpd_checker (.*);

FILE: verif/complex_field_peak_detector_test.sv
// ----------------------------------------------------------------------------
// complex_field_peak_detector_test
// Self-checking bench for the complex field peak detector. Samples are fed
// in raster order while the receiver stalls at random. A local copy of the
// line buffers and the raster position predicts every peak word, and each
// word that comes out is checked against the oldest prediction. Small frames
// and out-of-range geometry get most of the runs.
// ----------------------------------------------------------------------------
module complex_field_peak_detector_test;
  import cfpd_pkg::*;

  typedef struct {
    logic [15:0] re;
    logic [15:0] im;
    bit          drain_first;  // hold this word back until all peaks are out
  } sample_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_THRESHOLD;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [15:0]     in_re_part = '0;
  logic signed [15:0]     in_im_part = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [PCOL_W-1:0]      out_peak_col;
  logic [ROW_W-1:0]       out_peak_row;
  logic [MAG_W-1:0]       out_height_sq;
  logic                   out_last_of_run;

  // local copy of the detector state
  logic [31:0] thr_sq;
  int          geo_w;
  int          geo_h;
  int          col_pos;
  int          row_pos;
  logic [31:0] upper_mag [0:MAX_WIDTH_DEF-1];
  logic [31:0] middle_mag [0:MAX_WIDTH_DEF-1];

  sample_t     pending_samples [$];
  res_t        expected_peaks [$];
  sample_t     cur_sample;
  int          samples_queued = 0;
  int          samples_taken = 0;
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  complex_field_peak_detector dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_re_part      (in_re_part),
    .in_im_part      (in_im_part),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_peak_col    (out_peak_col),
    .out_peak_row    (out_peak_row),
    .out_height_sq   (out_height_sq),
    .out_last_of_run (out_last_of_run)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] mag_sq(logic signed [15:0] re, logic signed [15:0] im);
    longint a;
    longint b;
    longint s;
    a = re;
    b = im;
    s = a * a + b * b;
    if (s > 64'sh0_FFFF_FFFF) s = 64'sh0_FFFF_FFFF;
    return s[31:0];
  endfunction

  // upper and left neighbours may tie, lower and right must be strictly below
  function automatic bit is_peak(logic [31:0] h, bit hu, logic [31:0] u, bit hl,
                                 logic [31:0] l, bit hd, logic [31:0] d, bit hr,
                                 logic [31:0] rt);
    return h > thr_sq && !(hu && h < u) && !(hl && h < l) &&
           !(hd && h <= d) && !(hr && h <= rt);
  endfunction

  function automatic res_t make_peak(int c, int r, logic [31:0] h);
    res_t p;
    p.peak_col  = c[PCOL_W-1:0];
    p.peak_row  = r[ROW_W-1:0];
    p.height_sq = h;
    p.last      = 1'b0;
    return p;
  endfunction

  task automatic predict_peaks(input logic [15:0] re, input logic [15:0] im);
    int          w;
    int          hh;
    int          c;
    int          r;
    logic [31:0] h;
    res_t        found [$];
    w  = (geo_w < 1) ? 1 : (geo_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : geo_w;
    hh = (geo_h < 1) ? 1 : (geo_h > MAX_HEIGHT) ? MAX_HEIGHT : geo_h;
    if (col_pos >= w || row_pos >= hh) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    h = mag_sq(re, im);
    // the sample above is complete once its lower neighbour arrives
    if (r >= 1 && is_peak(middle_mag[c], r >= 2, upper_mag[c],
                          c >= 1, (c >= 1) ? upper_mag[c-1] : 32'd0,
                          1'b1, h,
                          c + 1 < w, (c + 1 < w) ? middle_mag[c+1] : 32'd0))
      found.push_back(make_peak(c, r - 1, middle_mag[c]));
    upper_mag[c]  = middle_mag[c];
    middle_mag[c] = h;
    if (r == hh - 1) begin
      if (c >= 1 && is_peak(middle_mag[c-1], r >= 1, upper_mag[c-1],
                            c >= 2, (c >= 2) ? middle_mag[c-2] : 32'd0,
                            1'b0, 32'd0, 1'b1, h))
        found.push_back(make_peak(c - 1, r, middle_mag[c-1]));
      if (c == w - 1 && is_peak(h, r >= 1, upper_mag[c],
                                c >= 1, (c >= 1) ? middle_mag[c-1] : 32'd0,
                                1'b0, 32'd0, 1'b0, 32'd0))
        found.push_back(make_peak(c, r, h));
    end
    if (c + 1 < w) begin
      col_pos = c + 1;
    end else begin
      col_pos = 0;
      row_pos = (r + 1 < hh) ? r + 1 : 0;
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) expected_peaks.push_back(found[i]);
  endtask

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_peaks(cur_sample.re, cur_sample.im);
        samples_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct &&
            !(pending_samples[0].drain_first && expected_peaks.size() > 0)) begin
          cur_sample = pending_samples.pop_front();
          in_valid   <= 1'b1;
          in_re_part <= cur_sample.re;
          in_im_part <= cur_sample.im;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // peak monitor
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_peaks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected peak word: col %0d row %0d height %h last %b",
                     out_peak_col, out_peak_row, out_height_sq, out_last_of_run);
        end else begin
          want = expected_peaks.pop_front();
          if (out_peak_col !== want.peak_col || out_peak_row !== want.peak_row ||
              out_height_sq !== want.height_sq || out_last_of_run !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("peak mismatch: expected col %0d row %0d height %h last %b,",
                       want.peak_col, want.peak_row, want.height_sq, want.last);
              $display("  got col %0d row %0d height %h last %b",
                       out_peak_col, out_peak_row, out_height_sq, out_last_of_run);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_sample(input logic [15:0] re, input logic [15:0] im,
                             input bit drain);
    sample_t s;
    s.re = re;
    s.im = im;
    s.drain_first = drain;
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  // all words taken, all peaks out, then a few cycles for the pipeline
  task automatic wait_quiet();
    while (samples_taken != samples_queued || expected_peaks.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_THRESHOLD: thr_sq = val;
      REG_WIDTH: begin
        geo_w   = val[FW_W-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      REG_HEIGHT: begin
        geo_h   = val[FH_W-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_setting(input logic [31:0] thr, input int w, input int hh);
    wait_quiet();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, hh);
  endtask

  // mostly full-range parts, with small values for ties and the extremes
  function automatic logic [15:0] rand_part();
    int unsigned pick;
    logic [31:0] v;
    pick = $urandom_range(99);
    if (pick < 60) v = $urandom;
    else if (pick < 85) v = $urandom_range(0, 6) - 3;
    else if (pick < 92) v = 32'h8000;
    else if (pick < 97) v = 32'h7FFF;
    else v = 32'h0;
    return v[15:0];
  endfunction

  task automatic queue_random(input int n, input bit drain_head);
    for (int i = 0; i < n; i++)
      push_sample(rand_part(), rand_part(), (i == 0 && drain_head) || $urandom_range(99) < 4);
  endtask

  task automatic random_phase();
    logic [31:0] thr;
    int          w;
    int          hh;
    int          ew;
    int          eh;
    int          n;
    int          split;
    case ($urandom_range(2))
      0: thr = 32'd0;
      1: thr = $urandom >> $urandom_range(1, 6);
      default: thr = $urandom_range(0, 1000);
    endcase
    w  = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
    hh = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
    ew = (w < 1) ? 1 : w;
    eh = (hh < 1) ? 1 : hh;
    n  = ew * eh + $urandom_range(0, 2 * ew);
    split = n / 2;
    load_setting(thr, w, hh);
    queue_random(split, 1'b0);
    // rewriting one geometry register alone must also restart the frame
    if ($urandom_range(1)) begin
      wait_quiet();
      if ($urandom_range(1)) write_reg(REG_WIDTH, w);
      else write_reg(REG_HEIGHT, hh);
    end
    queue_random(n - split, 1'b1);
  endtask

  initial begin
    for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
      upper_mag[i]  = '0;
      middle_mag[i] = '0;
    end
    thr_sq  = '0;
    geo_w   = CFG_WIDTH_RST;
    geo_h   = CFG_HEIGHT_RST;
    col_pos = 0;
    row_pos = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 18;
    recv_stall_pct = 81;

    // 3x3 frame with extreme parts and a center equal to its left neighbour
    load_setting(32'd0, 3, 3);
    push_sample(16'h0000, 16'h0000, 1'b0);
    push_sample(16'h8000, 16'h0000, 1'b0);
    push_sample(16'h0001, 16'h0001, 1'b0);
    push_sample(16'h8000, 16'h8000, 1'b0);
    push_sample(16'h8000, 16'h8000, 1'b0);
    push_sample(16'h7FFF, 16'h7FFF, 1'b0);
    push_sample(16'h0000, 16'h8000, 1'b0);
    push_sample(16'hFFFF, 16'h0001, 1'b0);
    push_sample(16'h7FFF, 16'h8000, 1'b0);
    // flat frame: only the bottom right corner survives the strict tests
    for (int i = 0; i < 9; i++) push_sample(16'h0003, 16'hFFFC, 1'b0);
    // zero geometry saturates to single-sample frames
    load_setting(32'h7FFF_FFFF, 0, 0);
    push_sample(16'h8000, 16'h8000, 1'b0);
    push_sample(16'h7FFF, 16'h7FFF, 1'b0);
    push_sample(16'h8000, 16'h0000, 1'b0);
    push_sample(16'h0000, 16'h0000, 1'b0);

    repeat (2) random_phase();
    send_idle_pct  = 81;
    recv_stall_pct = 18;
    repeat (2) random_phase();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) random_phase();

    // oversized width with one row: every sample sits in the last row
    load_setting(32'd0, 2047, 0);
    queue_random(30, 1'b0);
    // oversized height
    load_setting($urandom_range(0, 1000), 3, 8191);
    queue_random(30, 1'b1);
    // thresholds at and above the largest magnitude let nothing through
    load_setting(32'hFFFF_FFFF, 4, 3);
    queue_random(14, 1'b0);
    load_setting(32'h8000_0000, 3, 3);
    for (int i = 0; i < 9; i++) push_sample(16'h8000, 16'h8000, 1'b0);

    wait_quiet();
    if (mismatches == 0 && expected_peaks.size() == 0)
      $display("complex_field_peak_detector_test passed");
    else
      $display("complex_field_peak_detector_test failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("complex_field_peak_detector_test failed");
    $finish;
  end

endmodule

FILE: sim.f
sv/cfpd_pkg.sv
sv/cfpd_ram.sv
sv/cfpd_mag.sv
sv/cfpd_judge.sv
sv/cfpd_res_fifo.sv
sv/complex_field_peak_detector.sv
sv/cfpd_checker.sv
verif/complex_field_peak_detector_test.sv
